>>> design/amasm_pkg.sv
// Shared types, codes and helpers for the admittance matrix assembler.
// No dependencies; every other design file imports this package.
package amasm_pkg;

	localparam int MAX_NODES   = 16;
	localparam int NODE_W      = $clog2(MAX_NODES);
	localparam int NCNT_W      = NODE_W + 1;
	localparam int MAX_ENTRIES = 32;
	localparam int ENTRY_W     = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = ENTRY_W + 1;

	// Input command codes.
	localparam logic [2:0] CMD_LINE   = 3'd0;
	localparam logic [2:0] CMD_SHUNT  = 3'd1;
	localparam logic [2:0] CMD_XFMR   = 3'd2;
	localparam logic [2:0] CMD_FILL   = 3'd3;
	localparam logic [2:0] CMD_FINISH = 3'd4;

	// Work codes passed from the front to the back.
	localparam logic [2:0] OP_SHUNT_ADD = 3'd0;
	localparam logic [2:0] OP_SHUNT_INV = 3'd1;
	localparam logic [2:0] OP_FILL      = 3'd2;
	localparam logic [2:0] OP_LINE      = 3'd3;
	localparam logic [2:0] OP_XFMR      = 3'd4;
	localparam logic [2:0] OP_FINISH    = 3'd5;

	localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
	localparam logic signed [39:0] SAT_MAX = 40'sh00_7FFF_FFFF;
	localparam logic signed [39:0] SAT_MIN = 40'shFF_8000_0000;

	typedef struct packed {
		logic [2:0]        op;
		logic [NODE_W-1:0] from_idx;
		logic [NODE_W-1:0] to_idx;
		logic signed [31:0] r;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] k;
	} item_t;

	typedef struct packed {
		logic [63:0] num;
		logic        num_neg;
		logic [63:0] den;
		logic        den_neg;
	} div_req_t;

	typedef struct packed {
		logic               off;
		logic [NCNT_W-1:0]  row;
		logic [NCNT_W-1:0]  col;
		logic signed [31:0] g;
		logic signed [31:0] b;
		logic [CNT_W-1:0]   start;
		logic               last;
	} res_t;

	function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
		logic signed [31:0] r;
		if (v > SAT_MAX) r = Q_MAX;
		else if (v < SAT_MIN) r = Q_MIN;
		else r = v[31:0];
		return r;
	endfunction

	function automatic logic [31:0] mag32(input logic signed [31:0] v);
		logic [31:0] r;
		r = v[31] ? 32'(-v) : 32'(v);
		return r;
	endfunction

	function automatic logic [NCNT_W-1:0] popcnt(input logic [MAX_NODES-1:0] v);
		logic [NCNT_W-1:0] c;
		c = '0;
		for (int i = 0; i < MAX_NODES; i++) c = c + NCNT_W'(v[i]);
		return c;
	endfunction

endpackage

>>> design/amasm_front.sv
// Front end: accepts network elements, checks node ranges and classifies them.
// Depends on amasm_pkg; feeds amasm_queue.
module amasm_front import amasm_pkg::*; (
	input  logic               s_valid,
	output logic               s_ready,
	input  logic [2:0]         command,
	input  logic [NCNT_W-1:0]  from_node,
	input  logic [NCNT_W-1:0]  to_node,
	input  logic signed [31:0] resistance,
	input  logic signed [31:0] reactance,
	input  logic signed [31:0] half_charging,
	input  logic signed [31:0] turns_ratio,
	input  logic [NCNT_W-1:0]  n_eff,
	input  logic               q_full,
	output logic               push,
	output item_t              item
);

	logic nodes_ok;
	logic keep;

	assign s_ready  = !q_full;
	assign nodes_ok = (from_node != '0) && (from_node <= n_eff) &&
	                  (to_node != '0) && (to_node <= n_eff);

	always_comb begin
		item.from_idx = NODE_W'(from_node - NCNT_W'(1));
		item.to_idx   = NODE_W'(to_node - NCNT_W'(1));
		item.r        = resistance;
		item.x        = reactance;
		item.y        = half_charging;
		item.k        = turns_ratio;
		item.op       = OP_FINISH;
		keep          = 1'b0;
		// A line between equal nodes behaves like a ground shunt.
		priority if (command == CMD_FINISH) begin
			keep = 1'b1;
		end else if (!nodes_ok) begin
			keep = 1'b0;
		end else if (command == CMD_SHUNT || (command == CMD_LINE && from_node == to_node)) begin
			keep    = 1'b1;
			item.op = half_charging[31] ? OP_SHUNT_ADD : OP_SHUNT_INV;
		end else if (command == CMD_LINE) begin
			keep    = 1'b1;
			item.op = OP_LINE;
		end else if (command == CMD_XFMR) begin
			keep    = 1'b1;
			item.op = OP_XFMR;
		end else if (command == CMD_FILL) begin
			keep    = from_node != to_node;
			item.op = OP_FILL;
		end else begin
			keep = 1'b0;
		end
	end

	assign push = s_valid && s_ready && keep;

endmodule

>>> design/amasm_queue.sv
// Two-entry queue of classified work items between the front and the back.
// Depends on amasm_pkg for the item type.
module amasm_queue import amasm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	output logic  valid,
	input  logic  pop,
	output item_t pop_item
);

	item_t       slot_q [2];
	logic        wr_q;
	logic        rd_q;
	logic [1:0]  cnt_q;

	assign full     = cnt_q == 2'd2;
	assign valid    = cnt_q != 2'd0;
	assign pop_item = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

>>> design/amasm_div.sv
// Bit-serial restoring divider on 64-bit magnitudes with signed saturation.
// Depends on amasm_pkg; used by amasm_back for every quotient.
module amasm_div import amasm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  div_req_t           req,
	output logic               done,
	output logic signed [31:0] quot
);

	logic        busy_q;
	logic [5:0]  cnt_q;
	logic [63:0] rem_q;
	logic [63:0] num_q;
	logic [63:0] den_q;
	logic [63:0] quo_q;
	logic        neg_q;
	logic        done_q;
	logic signed [31:0] quot_q;

	logic [64:0] rem_sh;
	logic        fits;
	logic [63:0] rem_nx;
	logic [63:0] quo_nx;
	logic signed [31:0] sat_res;

	assign rem_sh = {rem_q, num_q[63]};
	assign fits   = rem_sh >= {1'b0, den_q};
	assign rem_nx = fits ? 64'(rem_sh - {1'b0, den_q}) : rem_sh[63:0];
	assign quo_nx = {quo_q[62:0], fits};

	always_comb begin
		if (quo_nx == '0) sat_res = '0;
		else if (neg_q) sat_res = (quo_nx > 64'h8000_0000) ? Q_MIN : 32'(-quo_nx[31:0]);
		else sat_res = (quo_nx > 64'h7FFF_FFFF) ? Q_MAX : quo_nx[31:0];
	end

	assign done = done_q;
	assign quot = quot_q;

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= req.num;
			den_q <= req.den;
			neg_q <= req.num_neg != req.den_neg;
			rem_q <= '0;
			quo_q <= '0;
			if (req.den == '0) quot_q <= (req.num == '0) ? '0 : (req.num_neg ? Q_MIN : Q_MAX);
		end else if (busy_q) begin
			rem_q <= rem_nx;
			num_q <= {num_q[62:0], 1'b0};
			quo_q <= quo_nx;
			if (cnt_q == 6'd63) quot_q <= sat_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= '0;
				// A zero divisor needs no iterations.
				if (req.den == '0) done_q <= 1'b1;
				else busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

>>> design/amasm_back.sv
// Back end: element arithmetic, diagonal and entry stores, and the finish burst.
// Depends on amasm_pkg and instantiates amasm_div; drives the result register.
module amasm_back import amasm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [NCNT_W-1:0] n_eff,
	input  logic              q_valid,
	input  item_t             q_item,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_ready,
	output res_t              out_res
);

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_MUL1     = 4'd1;
	localparam logic [3:0] S_MUL2     = 4'd2;
	localparam logic [3:0] S_DIV      = 4'd3;
	localparam logic [3:0] S_UPD_FROM = 4'd4;
	localparam logic [3:0] S_UPD_TO   = 4'd5;
	localparam logic [3:0] S_STORE    = 4'd6;
	localparam logic [3:0] S_FIN_DIAG = 4'd7;
	localparam logic [3:0] S_FIN_POS  = 4'd8;
	localparam logic [3:0] S_FIN_SCAN = 4'd9;
	localparam logic [3:0] S_FIN_ACC  = 4'd10;
	localparam logic [3:0] S_FIN_EMIT = 4'd11;

	localparam logic [2:0] DS_G   = 3'd0;
	localparam logic [2:0] DS_B   = 3'd1;
	localparam logic [2:0] DS_GK  = 3'd2;
	localparam logic [2:0] DS_BK  = 3'd3;
	localparam logic [2:0] DS_GK2 = 3'd4;
	localparam logic [2:0] DS_BK2 = 3'd5;
	localparam logic [2:0] DS_INV = 3'd6;

	typedef struct packed {
		logic [NODE_W-1:0]  row;
		logic [NODE_W-1:0]  col;
		logic signed [31:0] g;
		logic signed [31:0] b;
	} entry_t;

	logic [3:0]  st_q;
	item_t       it_q;
	logic [63:0] sqr_q;
	logic [63:0] den_q;
	logic signed [31:0] g_q, b_q, gk_q, bk_q, gk2_q, bk2_q, eg_q, eb_q;
	logic [2:0]  dsel_q;
	logic        drun_q;
	logic signed [33:0] term_g_q, term_b_q;
	logic [CNT_W-1:0] count_q;
	logic [MAX_NODES-1:0] bitmap_q [MAX_NODES];
	logic signed [31:0] diag_g_q [MAX_NODES];
	logic signed [31:0] diag_b_q [MAX_NODES];
	logic [CNT_W-1:0] row_first_q [MAX_NODES];
	entry_t      mem [MAX_ENTRIES];
	entry_t      rd_s1;
	logic        rd_v_s1;
	logic [NODE_W-1:0] ri_q;
	logic [CNT_W-1:0]  cnt_q, total_q, emitted_q;
	logic [2*NODE_W-1:0] pos_q;
	logic [ENTRY_W-1:0] e_q;
	logic signed [39:0] sum_g_q, sum_b_q;
	logic        out_valid_q;
	res_t        out_q;

	div_req_t    dreq;
	logic        div_start, div_done;
	logic signed [31:0] div_quot;
	logic [NODE_W-1:0] upd_idx, pr, pc, lo_idx, hi_idx;
	logic signed [31:0] upd_g, upd_b;
	logic [MAX_NODES-1:0] colmask;
	logic        slot_free, out_load, ri_last, hit, match, emit_last;
	res_t        load_res;

	assign pr        = pos_q[2*NODE_W-1:NODE_W];
	assign pc        = pos_q[NODE_W-1:0];
	assign slot_free = !out_valid_q || out_ready;
	assign ri_last   = NCNT_W'(ri_q) == n_eff - NCNT_W'(1);
	assign hit       = bitmap_q[pr][pc] && colmask[pc];
	assign match     = rd_v_s1 && rd_s1.row == pr && rd_s1.col == pc;
	assign emit_last = (emitted_q + CNT_W'(1)) == total_q;
	assign lo_idx    = (it_q.from_idx < it_q.to_idx) ? it_q.from_idx : it_q.to_idx;
	assign hi_idx    = (it_q.from_idx < it_q.to_idx) ? it_q.to_idx : it_q.from_idx;
	assign upd_idx   = (st_q == S_UPD_TO) ? it_q.to_idx : it_q.from_idx;
	assign upd_g     = sat32(40'(diag_g_q[upd_idx]) + 40'(term_g_q));
	assign upd_b     = sat32(40'(diag_b_q[upd_idx]) + 40'(term_b_q));
	assign q_pop     = st_q == S_IDLE && q_valid;
	assign div_start = st_q == S_DIV && !drun_q;

	always_comb begin
		for (int i = 0; i < MAX_NODES; i++) colmask[i] = NCNT_W'(i) < n_eff;
	end

	always_comb begin
		dreq.num     = {16'd0, mag32(g_q), 16'd0};
		dreq.num_neg = g_q[31];
		dreq.den     = {32'd0, mag32(it_q.k)};
		dreq.den_neg = it_q.k[31];
		unique case (dsel_q)
			DS_G: begin
				dreq.num     = {mag32(it_q.r), 32'd0};
				dreq.num_neg = it_q.r[31];
				dreq.den     = den_q;
				dreq.den_neg = 1'b0;
			end
			DS_B: begin
				dreq.num     = {mag32(it_q.x), 32'd0};
				dreq.num_neg = !it_q.x[31] && it_q.x != '0;
				dreq.den     = den_q;
				dreq.den_neg = 1'b0;
			end
			DS_GK: begin
			end
			DS_BK: begin
				dreq.num     = {16'd0, mag32(b_q), 16'd0};
				dreq.num_neg = b_q[31];
			end
			DS_GK2: begin
				dreq.num     = {16'd0, mag32(gk_q), 16'd0};
				dreq.num_neg = gk_q[31];
			end
			DS_BK2: begin
				dreq.num     = {16'd0, mag32(bk_q), 16'd0};
				dreq.num_neg = bk_q[31];
			end
			default: begin
				dreq.num     = 64'h1_0000_0000;
				dreq.num_neg = 1'b0;
				dreq.den     = {32'd0, mag32(it_q.x)};
				dreq.den_neg = it_q.x[31];
			end
		endcase
	end

	amasm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.req    (dreq),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_comb begin
		out_load       = 1'b0;
		load_res.off   = 1'b0;
		load_res.row   = NCNT_W'(ri_q) + NCNT_W'(1);
		load_res.col   = NCNT_W'(ri_q) + NCNT_W'(1);
		load_res.g     = diag_g_q[ri_q];
		load_res.b     = diag_b_q[ri_q];
		load_res.start = cnt_q + CNT_W'(1);
		load_res.last  = ri_last && cnt_q == '0;
		if (st_q == S_FIN_DIAG) begin
			out_load = slot_free;
		end else if (st_q == S_FIN_EMIT) begin
			out_load       = slot_free;
			load_res.off   = 1'b1;
			load_res.row   = NCNT_W'(pr) + NCNT_W'(1);
			load_res.col   = NCNT_W'(pc) + NCNT_W'(1);
			load_res.g     = sat32(sum_g_q);
			load_res.b     = sat32(sum_b_q);
			load_res.start = row_first_q[pr];
			load_res.last  = emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	// Entry store and its registered read port.
	always_ff @(posedge clk) begin
		if (st_q == S_STORE && count_q < CNT_W'(MAX_ENTRIES)) begin
			mem[count_q[ENTRY_W-1:0]] <= '{row: lo_idx, col: hi_idx,
				g: sat32(-40'(eg_q)), b: sat32(-40'(eb_q))};
		end
		rd_s1 <= mem[e_q];
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (q_pop) it_q <= q_item;
		if (out_load) out_q <= load_res;
		if (st_q == S_FIN_DIAG && out_load) row_first_q[ri_q] <= cnt_q + CNT_W'(1);
		if (st_q == S_MUL1) sqr_q <= mag32(it_q.r) * mag32(it_q.r);
		if (st_q == S_MUL2) den_q <= sqr_q + mag32(it_q.x) * mag32(it_q.x);
		if (st_q == S_FIN_POS) begin
			sum_g_q <= '0;
			sum_b_q <= '0;
		end else if (match) begin
			sum_g_q <= sum_g_q + 40'(rd_s1.g);
			sum_b_q <= sum_b_q + 40'(rd_s1.b);
		end
		if (st_q == S_DIV && drun_q && div_done) begin
			unique case (dsel_q)
				DS_G:    g_q <= div_quot;
				DS_B:    b_q <= div_quot;
				DS_GK:   gk_q <= div_quot;
				DS_BK:   bk_q <= div_quot;
				DS_GK2:  gk2_q <= div_quot;
				DS_BK2:  bk2_q <= div_quot;
				default: g_q <= g_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			dsel_q      <= DS_G;
			drun_q      <= 1'b0;
			term_g_q    <= '0;
			term_b_q    <= '0;
			eg_q        <= '0;
			eb_q        <= '0;
			count_q     <= '0;
			ri_q        <= '0;
			cnt_q       <= '0;
			total_q     <= '0;
			emitted_q   <= '0;
			pos_q       <= '0;
			e_q         <= '0;
			rd_v_s1     <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < MAX_NODES; i++) begin
				bitmap_q[i] <= '0;
				diag_g_q[i] <= '0;
				diag_b_q[i] <= '0;
			end
		end else begin
			rd_v_s1 <= st_q == S_FIN_SCAN;
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;

			unique case (st_q)
				S_IDLE: begin
					if (q_valid) begin
						unique case (q_item.op)
							OP_SHUNT_ADD: begin
								term_g_q <= '0;
								term_b_q <= 34'(q_item.x);
								st_q     <= S_UPD_FROM;
							end
							OP_SHUNT_INV: begin
								dsel_q <= DS_INV;
								st_q   <= S_DIV;
							end
							OP_FILL: begin
								eg_q <= '0;
								eb_q <= '0;
								st_q <= S_STORE;
							end
							OP_LINE, OP_XFMR: st_q <= S_MUL1;
							OP_FINISH: begin
								ri_q  <= '0;
								cnt_q <= '0;
								st_q  <= S_FIN_DIAG;
							end
							default: st_q <= S_IDLE;
						endcase
					end
				end
				S_MUL1: st_q <= S_MUL2;
				S_MUL2: begin
					dsel_q <= DS_G;
					st_q   <= S_DIV;
				end
				S_DIV: begin
					if (!drun_q) begin
						drun_q <= 1'b1;
					end else if (div_done) begin
						drun_q <= 1'b0;
						unique case (dsel_q)
							DS_G: dsel_q <= DS_B;
							DS_B: begin
								if (it_q.op == OP_LINE) begin
									term_g_q <= 34'(g_q);
									term_b_q <= 34'(it_q.y) + 34'(div_quot);
									eg_q     <= g_q;
									eb_q     <= div_quot;
									st_q     <= S_UPD_FROM;
								end else begin
									dsel_q <= DS_GK;
								end
							end
							DS_GK: dsel_q <= DS_BK;
							DS_BK: begin
								eg_q   <= gk_q;
								eb_q   <= div_quot;
								dsel_q <= DS_GK2;
							end
							DS_GK2: dsel_q <= DS_BK2;
							DS_BK2: begin
								term_g_q <= 34'(g_q);
								term_b_q <= 34'(b_q);
								st_q     <= S_UPD_FROM;
							end
							default: begin
								term_g_q <= '0;
								term_b_q <= -34'(div_quot);
								st_q     <= S_UPD_FROM;
							end
						endcase
					end
				end
				S_UPD_FROM: begin
					diag_g_q[upd_idx] <= upd_g;
					diag_b_q[upd_idx] <= upd_b;
					if (it_q.op == OP_XFMR) begin
						term_g_q <= 34'(gk2_q);
						term_b_q <= 34'(bk2_q);
						st_q     <= S_UPD_TO;
					end else if (it_q.op == OP_LINE) begin
						st_q <= S_UPD_TO;
					end else begin
						st_q <= S_IDLE;
					end
				end
				S_UPD_TO: begin
					diag_g_q[upd_idx] <= upd_g;
					diag_b_q[upd_idx] <= upd_b;
					// A transformer with equal end nodes records no entry.
					if (it_q.from_idx != it_q.to_idx) st_q <= S_STORE;
					else st_q <= S_IDLE;
				end
				S_STORE: begin
					if (count_q < CNT_W'(MAX_ENTRIES)) begin
						count_q <= count_q + CNT_W'(1);
						bitmap_q[lo_idx][hi_idx] <= 1'b1;
					end
					st_q <= S_IDLE;
				end
				S_FIN_DIAG: begin
					if (out_load) begin
						cnt_q <= cnt_q + CNT_W'(popcnt(bitmap_q[ri_q] & colmask));
						if (ri_last) begin
							total_q   <= cnt_q;
							emitted_q <= '0;
							pos_q     <= '0;
							st_q      <= (cnt_q == '0) ? S_IDLE : S_FIN_POS;
						end else begin
							ri_q <= ri_q + NODE_W'(1);
						end
					end
				end
				S_FIN_POS: begin
					if (hit) begin
						e_q  <= '0;
						st_q <= S_FIN_SCAN;
					end else begin
						pos_q <= pos_q + (2*NODE_W)'(1);
					end
				end
				S_FIN_SCAN: begin
					if (CNT_W'(e_q) == count_q - CNT_W'(1)) st_q <= S_FIN_ACC;
					else e_q <= e_q + ENTRY_W'(1);
				end
				S_FIN_ACC: st_q <= S_FIN_EMIT;
				S_FIN_EMIT: begin
					if (out_load) begin
						emitted_q <= emitted_q + CNT_W'(1);
						if (emit_last) begin
							st_q <= S_IDLE;
						end else begin
							pos_q <= pos_q + (2*NODE_W)'(1);
							st_q  <= S_FIN_POS;
						end
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_ENTRIES))
		else $error("entry count above store depth");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !out_load)
		else $error("result register overwritten while stalled");

	a_burst_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && load_res.last) |=> st_q == S_IDLE)
		else $error("sequencer busy after final result");

	a_pos_pending: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_FIN_POS |-> emitted_q < total_q)
		else $error("position walk past the last merged entry");

endmodule

>>> design/admittance_matrix_assembler_core.sv
// Top level of the admittance matrix assembler: ports, node count register, wiring.
// Depends on amasm_pkg, amasm_front, amasm_queue, amasm_div and amasm_back.
//
// Network elements stream in one per transfer and are checked and classified at once;
// up to two classified elements wait in a queue while the back end works. The back end
// handles one element at a time and its time is set by the shared 64-step divider:
// a shunt given as susceptance or a fill-in position needs no quotient, a shunt given
// as reactance one quotient, a line two and a transformer six. Finish emits the
// effective node count of diagonals first, one per cycle while the output is not stalled,
// then walks the 256 matrix positions one per cycle up to the last occupied one and, for
// each occupied position, reads every stored entry before sending the merged off-diagonal.
module admittance_matrix_assembler_core import amasm_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_wen,
	input  logic [4:0]    cfg_wdata,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	// from_node[4:0], to_node[9:5], resistance[41:10], reactance[73:42],
	// half_charging[105:74], turns_ratio[137:106], zero fill up to bit 143
	input  logic [143:0]  s_axis_tdata,
	// command[2:0]
	input  logic [2:0]    s_axis_tuser,
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	// row[4:0], column[9:5], conductance[41:10], susceptance[73:42], row_start[79:74]
	output logic [79:0]   m_axis_tdata,
	// is_off_diagonal[0]
	output logic          m_axis_tuser,
	output logic          m_axis_tlast
);

	logic [NCNT_W-1:0] node_count_q;
	logic [NCNT_W-1:0] n_eff;
	logic   q_full, q_valid, q_pop, push;
	item_t  push_item, pop_item;
	res_t   res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) node_count_q <= NCNT_W'(MAX_NODES);
		else if (cfg_wen) node_count_q <= cfg_wdata;
	end

	// Zero acts as one node; values above the matrix size clamp to it.
	always_comb begin
		priority if (node_count_q == '0) n_eff = NCNT_W'(1);
		else if (node_count_q > NCNT_W'(MAX_NODES)) n_eff = NCNT_W'(MAX_NODES);
		else n_eff = node_count_q;
	end

	amasm_front u_front (
		.s_valid       (s_axis_tvalid),
		.s_ready       (s_axis_tready),
		.command       (s_axis_tuser),
		.from_node     (s_axis_tdata[4:0]),
		.to_node       (s_axis_tdata[9:5]),
		.resistance    (s_axis_tdata[41:10]),
		.reactance     (s_axis_tdata[73:42]),
		.half_charging (s_axis_tdata[105:74]),
		.turns_ratio   (s_axis_tdata[137:106]),
		.n_eff         (n_eff),
		.q_full        (q_full),
		.push          (push),
		.item          (push_item)
	);

	amasm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.valid     (q_valid),
		.pop       (q_pop),
		.pop_item  (pop_item)
	);

	amasm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.n_eff     (n_eff),
		.q_valid   (q_valid),
		.q_item    (pop_item),
		.q_pop     (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (res)
	);

	assign m_axis_tdata = {res.start, res.b, res.g, res.col, res.row};
	assign m_axis_tuser = res.off;
	assign m_axis_tlast = res.last;

endmodule
